### hw/rtl/murmur3_32_hash_top_defines.svh
// assertion macros shared by the hash checker
`ifndef MURMUR3_32_HASH_TOP_DEFINES_SVH
`define MURMUR3_32_HASH_TOP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent, outside reset
`define MMH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmh checker: next-cycle property failed");

// consequent must hold in the same cycle, outside reset
`define MMH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmh checker: same-cycle property failed");

// reset behavior, checked with reset itself as the trigger
`define MMH_ASSERT_RESET(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mmh checker: reset property failed");

`endif

### hw/rtl/mmh_pkg.sv
// shared types and constants of the murmur3 x86_32 hash block
package mmh_pkg;

  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

  // how a mixed word enters the running hash
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  count;
    logic        last;
    logic [31:0] k;
  } blk_t;

  typedef enum logic [1:0] {
    ST_FOLD,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } back_state_t;

endpackage

### hw/rtl/mmh_front.sv
// front end: takes input beats, classifies them and mixes the word with c1/c2
module mmh_front
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_item,
  input  logic        q_full,
  output logic        q_push,
  output blk_t        q_data
);

  logic        s1_valid;
  logic        s2_valid;
  blk_t        s1;
  blk_t        s2;
  logic        stall;
  logic [2:0]  cnt_eff;
  logic [31:0] masked;
  kind_t       kind_in;
  logic [31:0] rot1;

  assign stall  = s2_valid && q_full;
  assign full   = stall;
  assign q_push = s2_valid && !q_full;
  assign q_data = s2;

  always_comb begin
    if (!last_item || byte_count > 3'd4) begin
      cnt_eff = 3'd4;
    end else begin
      cnt_eff = byte_count;
    end
    unique case (cnt_eff)
      3'd1:    masked = {24'd0, data_word[7:0]};
      3'd2:    masked = {16'd0, data_word[15:0]};
      3'd3:    masked = {8'd0, data_word[23:0]};
      3'd4:    masked = data_word;
      default: masked = 32'd0;
    endcase
    if (cnt_eff == 3'd4) begin
      kind_in = KIND_FULL;
    end else if (cnt_eff == 3'd0) begin
      kind_in = KIND_NONE;
    end else begin
      kind_in = KIND_TAIL;
    end
  end

  assign rot1 = {s1.k[16:0], s1.k[31:17]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1.kind  <= kind_in;
      s1.count <= cnt_eff;
      s1.last  <= last_item;
      s1.k     <= masked * MIX_C1;
      s2.kind  <= s1.kind;
      s2.count <= s1.count;
      s2.last  <= s1.last;
      s2.k     <= rot1 * MIX_C2;
    end
  end

endmodule

### hw/rtl/mmh_fifo.sv
// short queue of mixed blocks between front and back
module mmh_fifo
  import mmh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  blk_t wr_data,
  output logic full,
  input  logic rd_en,
  output blk_t rd_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  blk_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### hw/rtl/mmh_back.sv
// back end: folds blocks into the running hash, finalizes and holds the result
module mmh_back
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] seed,
  input  logic        q_empty,
  output logic        q_pop,
  input  blk_t        q_data,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value
);

  back_state_t state;
  back_state_t state_next;
  logic        in_msg;
  logic [31:0] hash;
  logic [31:0] len;
  logic [31:0] fin;
  logic        res_valid;
  logic [31:0] res;
  logic [31:0] h0;
  logic [31:0] len0;
  logic [31:0] hx;
  logic [31:0] hr;
  logic [31:0] h1;
  logic [31:0] len1;
  logic        res_free;

  assign empty      = !res_valid;
  assign hash_value = res;
  assign res_free   = !res_valid || pop;

  // fold datapath
  always_comb begin
    h0   = in_msg ? hash : seed;
    len0 = in_msg ? len : 32'd0;
    hx   = h0 ^ q_data.k;
    hr   = {hx[18:0], hx[31:19]};
    unique case (q_data.kind)
      KIND_FULL: h1 = {hr[29:0], 2'b00} + hr + FOLD_ADD;
      KIND_TAIL: h1 = hx;
      default:   h1 = h0;
    endcase
    len1 = len0 + {29'd0, q_data.count};
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_FOLD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.last) begin
            state_next = ST_FIN1;
          end
        end
      end
      ST_FIN1: state_next = ST_FIN2;
      ST_FIN2: state_next = ST_FIN3;
      ST_FIN3: begin
        if (res_free) begin
          state_next = ST_FOLD;
        end
      end
      default: state_next = ST_FOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FOLD;
      in_msg    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        in_msg <= !q_data.last;
      end
      if (state == ST_FIN3 && res_free) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hash <= h1;
      len  <= len1;
      fin  <= h1 ^ len1;
    end else if (state == ST_FIN1) begin
      fin <= (fin ^ {16'd0, fin[31:16]}) * FIN_M1;
    end else if (state == ST_FIN2) begin
      fin <= (fin ^ {13'd0, fin[31:13]}) * FIN_M2;
    end
    if (state == ST_FIN3 && res_free) begin
      res <= fin ^ {16'd0, fin[31:16]};
    end
  end

endmodule

### hw/rtl/murmur3_32_hash_top.sv
// top level of the streaming murmur3 x86_32 hash
//
//   channel  direction  handshake            payload
//   input    in         push / full          data_word, byte_count, last_item
//   result   out        empty / pop          hash_value
//   config   in         cfg_valid/cfg_ready  hash_seed
//
// one input beat per cycle is taken while the block queue has room
// a beat passes the c1/c2 mixing registers s1 and s2, then the block queue and
// the fold; a last beat then runs the finalizer states ST_FIN1, ST_FIN2 and
// ST_FIN3 in the back end (fmix32 multiplies) before its hash is registered
// reset is synchronous and empties every stage; the seed resets to zero
// a result not popped holds the back end in its last finalizer cycle; the
// queue and the mixer then fill up and full rises
module murmur3_32_hash_top
  import mmh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_item,
  // result beats
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value,
  // seed register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] hash_seed
);

  logic [31:0] seed;
  logic        q_full;
  logic        q_push;
  blk_t        q_wdata;
  logic        q_empty;
  logic        q_pop;
  blk_t        q_rdata;

  // seed is always writable; it is picked up at the next message start
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (cfg_valid) begin
      seed <= hash_seed;
    end
  end

  // classify the count and premix the word
  mmh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_item  (last_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // decouples the mixing pipeline from the serial fold
  mmh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // fold, length, finalizer and result register
  mmh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .empty      (empty),
    .pop        (pop),
    .hash_value (hash_value)
  );

endmodule

### hw/rtl/mmh_checker.sv
// port-level checker for the hash block and its bind
`include "murmur3_32_hash_top_defines.svh"

module mmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] hash_value,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a result not taken stays put
  `MMH_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(hash_value))

  // reset leaves no result and room for input
  `MMH_ASSERT_RESET(a_reset_clears, clk, rst, empty && !full)

  // the seed register never back-pressures
  `MMH_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid || !cfg_valid, cfg_ready)

  // back-pressure seen by a pushing sender is always a clean level
  `MMH_ASSERT_NOW(a_full_known, clk, rst, push, !$isunknown(full))

endmodule

bind murmur3_32_hash_top mmh_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .hash_value (hash_value),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
